@@ sv/cof_pkg.sv @@
`timescale 1ns / 1ps

package cof_pkg;

    localparam int QW = 16;
    localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;
    localparam int QUO_W = 15;
    localparam int NUM_W = 47;

    typedef logic signed [QW-1:0] q14_t;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
    } tangent_t;

    typedef struct packed {
        logic signed [QW-1:0] fwd_x;
        logic signed [QW-1:0] fwd_y;
        logic signed [QW-1:0] fwd_z;
        logic signed [QW-1:0] up_out_x;
        logic signed [QW-1:0] up_out_y;
        logic signed [QW-1:0] up_out_z;
        logic signed [QW-1:0] side_x;
        logic signed [QW-1:0] side_y;
        logic signed [QW-1:0] side_z;
        logic                 degenerate;
    } frame_t;

endpackage

@@ sv/cof_if.sv @@
`timescale 1ns / 1ps

interface cof_tangent_if;
    logic               valid;
    logic               ready;
    cof_pkg::tangent_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cof_frame_if;
    logic             valid;
    logic             ready;
    cof_pkg::frame_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/curve_orientation_frame.sv @@
`timescale 1ns / 1ps

// Builds a forward / side / up frame in Q1.14 from one Q16.16 tangent word and keeps the up
// vector for the next word. A word passes three normalizations and two cross products on its way
// to the result register; a zero length ends it early with the held frame flagged degenerate.
// Each normalization squares on the shared multiplier, then runs the one-bit-per-cycle square
// root and the one-bit-per-cycle quotient for three components.
// The input is not ready while a word is in work; a finished frame waits in the output
// register while the next tangent is taken.
module curve_orientation_frame (
    input  logic               clk,
    input  logic               rst_n,
    cof_tangent_if.sink        tangent,
    cof_frame_if.source        frame
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CROSS = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic [1:0]                     pass_reg, pass_next;
    logic [1:0]                     comp_reg, comp_next;
    logic                           ok_reg, ok_next;
    logic signed [31:0]             vec_reg [3];
    logic signed [31:0]             vec_next [3];
    logic [63:0]                    acc_reg, acc_next;
    logic signed [63:0]             prod_reg, prod_next;
    logic [63:0]                    n_reg, n_next;
    logic [cof_pkg::NUM_W-1:0]      rem_reg, rem_next;
    logic [31:0]                    root_reg, root_next;
    logic [cof_pkg::QUO_W-1:0]      quo_reg, quo_next;
    cof_pkg::q14_t                  fwd_w_reg [3];
    cof_pkg::q14_t                  fwd_w_next [3];
    cof_pkg::q14_t                  side_w_reg [3];
    cof_pkg::q14_t                  side_w_next [3];
    cof_pkg::q14_t                  up_w_reg [3];
    cof_pkg::q14_t                  up_w_next [3];
    cof_pkg::q14_t                  hfwd_reg [3];
    cof_pkg::q14_t                  hfwd_next [3];
    cof_pkg::q14_t                  hside_reg [3];
    cof_pkg::q14_t                  hside_next [3];
    cof_pkg::q14_t                  up_reg [3];
    cof_pkg::q14_t                  up_next [3];
    logic                           out_valid_reg, out_valid_next;
    cof_pkg::frame_t                out_reg, out_next;

    logic signed [32:0]             mul_a;
    logic signed [32:0]             mul_b;
    logic signed [65:0]             product;
    logic [31:0]                    mag0;
    logic [33:0]                    sq_rem;
    logic [33:0]                    sq_trial;
    logic [31:0]                    root_new;
    logic [cof_pkg::NUM_W-1:0]      div_trial;
    logic [cof_pkg::NUM_W-1:0]      num_first;
    logic [cof_pkg::NUM_W-1:0]      num_second;
    logic                           div_bit;
    logic [cof_pkg::QUO_W-1:0]      quo_new;
    cof_pkg::q14_t                  unit_val;
    cof_pkg::q14_t                  av [3];
    cof_pkg::q14_t                  bv [3];
    logic [2:0]                     cx;
    logic [63:0]                    sq_sum;

    assign product = mul_a * mul_b;
    assign mag0 = vec_reg[0][31] ? 32'(-vec_reg[0]) : 32'(vec_reg[0]);
    assign sq_sum = acc_reg + 64'(prod_reg);

    assign tangent.ready = (state_reg == S_IDLE);
    assign frame.valid = out_valid_reg;
    assign frame.data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pass_next = pass_reg;
        comp_next = comp_reg;
        ok_next = ok_reg;
        vec_next = vec_reg;
        acc_next = acc_reg;
        prod_next = prod_reg;
        n_next = n_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        quo_next = quo_reg;
        fwd_w_next = fwd_w_reg;
        side_w_next = side_w_reg;
        up_w_next = up_w_reg;
        hfwd_next = hfwd_reg;
        hside_next = hside_reg;
        up_next = up_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;

        mul_a = {1'b0, mag0};
        mul_b = {1'b0, mag0};
        sq_rem = {rem_reg[31:0], n_reg[63:62]};
        sq_trial = {root_reg, 2'b01};
        root_new = (sq_rem >= sq_trial) ? {root_reg[30:0], 1'b1} : {root_reg[30:0], 1'b0};
        div_trial = cof_pkg::NUM_W'(root_reg) << cnt_reg[3:0];
        div_bit = (rem_reg >= div_trial);
        quo_new = {quo_reg[cof_pkg::QUO_W-2:0], div_bit};
        unit_val = vec_reg[0][31] ? 16'sd0 - 16'(quo_new) : 16'(quo_new);
        num_first = {1'b0, mag0, 14'b0} + cof_pkg::NUM_W'(root_new >> 1);
        num_second = {1'b0, (vec_reg[1][31] ? 32'(-vec_reg[1]) : 32'(vec_reg[1])), 14'b0}
                     + cof_pkg::NUM_W'(root_reg >> 1);
        cx = cnt_reg[2:0] - 3'd1;

        for (int i = 0; i < 3; i++)
        begin
            av[i] = (pass_reg == 2'd1) ? fwd_w_reg[i] : side_w_reg[i];
            bv[i] = (pass_reg == 2'd1) ? up_reg[i] : fwd_w_reg[i];
        end

        if (frame.valid && frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (tangent.valid)
                begin
                    vec_next[0] = tangent.data.tangent_x;
                    vec_next[1] = tangent.data.tangent_y;
                    vec_next[2] = tangent.data.tangent_z;
                    pass_next = 2'd0;
                    cnt_next = '0;
                    acc_next = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // square each magnitude; rotate so component zero is always the one in hand
                if (cnt_reg != 5'd0)
                begin
                    acc_next = sq_sum;
                end
                if (cnt_reg == 5'd3)
                begin
                    n_next = sq_sum;
                    rem_next = '0;
                    root_next = '0;
                    cnt_next = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    prod_next = product[63:0];
                    vec_next[0] = vec_reg[1];
                    vec_next[1] = vec_reg[2];
                    vec_next[2] = vec_reg[0];
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_ROOT:
            begin
                rem_next = cof_pkg::NUM_W'((sq_rem >= sq_trial) ? sq_rem - sq_trial : sq_rem);
                root_next = root_new;
                n_next = {n_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (root_new == 32'd0)
                    begin
                        ok_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rem_next = num_first;
                        quo_next = '0;
                        comp_next = 2'd0;
                        cnt_next = 5'd14;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = div_bit ? rem_reg - div_trial : rem_reg;
                quo_next = quo_new;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    case (pass_reg)
                        2'd0:    fwd_w_next[comp_reg] = unit_val;
                        2'd1:    side_w_next[comp_reg] = unit_val;
                        default: up_w_next[comp_reg] = unit_val;
                    endcase
                    vec_next[0] = vec_reg[1];
                    vec_next[1] = vec_reg[2];
                    vec_next[2] = vec_reg[0];
                    if (comp_reg == 2'd2)
                    begin
                        cnt_next = '0;
                        if (pass_reg == 2'd2)
                        begin
                            ok_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            pass_next = pass_reg + 2'd1;
                            state_next = S_CROSS;
                        end
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        rem_next = num_second;
                        quo_next = '0;
                        cnt_next = 5'd14;
                    end
                end
            end
            S_CROSS:
            begin
                unique case (cnt_reg[2:0])
                    3'd0:
                    begin
                        mul_a = 33'(av[1]);
                        mul_b = 33'(bv[2]);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(av[2]);
                        mul_b = 33'(bv[1]);
                    end
                    3'd2:
                    begin
                        mul_a = 33'(av[2]);
                        mul_b = 33'(bv[0]);
                    end
                    3'd3:
                    begin
                        mul_a = 33'(av[0]);
                        mul_b = 33'(bv[2]);
                    end
                    3'd4:
                    begin
                        mul_a = 33'(av[0]);
                        mul_b = 33'(bv[1]);
                    end
                    3'd5:
                    begin
                        mul_a = 33'(av[1]);
                        mul_b = 33'(bv[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                prod_next = product[63:0];
                if (cnt_reg != 5'd0)
                begin
                    if (!cx[0])
                    begin
                        acc_next = 64'(prod_reg);
                    end
                    else
                    begin
                        vec_next[cx[2:1]] = 32'(64'(acc_reg) - 64'(prod_reg));
                    end
                end
                if (cnt_reg == 5'd6)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || frame.ready)
                begin
                    if (ok_reg)
                    begin
                        hfwd_next = fwd_w_reg;
                        hside_next = side_w_reg;
                        up_next = up_w_reg;
                        out_next.fwd_x = fwd_w_reg[0];
                        out_next.fwd_y = fwd_w_reg[1];
                        out_next.fwd_z = fwd_w_reg[2];
                        out_next.side_x = side_w_reg[0];
                        out_next.side_y = side_w_reg[1];
                        out_next.side_z = side_w_reg[2];
                        out_next.up_out_x = up_w_reg[0];
                        out_next.up_out_y = up_w_reg[1];
                        out_next.up_out_z = up_w_reg[2];
                    end
                    else
                    begin
                        out_next.fwd_x = hfwd_reg[0];
                        out_next.fwd_y = hfwd_reg[1];
                        out_next.fwd_z = hfwd_reg[2];
                        out_next.side_x = hside_reg[0];
                        out_next.side_y = hside_reg[1];
                        out_next.side_z = hside_reg[2];
                        out_next.up_out_x = up_reg[0];
                        out_next.up_out_y = up_reg[1];
                        out_next.up_out_z = up_reg[2];
                    end
                    out_next.degenerate = !ok_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            pass_reg <= '0;
            comp_reg <= '0;
            ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hfwd_reg[0] <= cof_pkg::Q_ONE;
            hfwd_reg[1] <= '0;
            hfwd_reg[2] <= '0;
            hside_reg[0] <= '0;
            hside_reg[1] <= '0;
            hside_reg[2] <= cof_pkg::Q_ONE;
            up_reg[0] <= '0;
            up_reg[1] <= cof_pkg::Q_ONE;
            up_reg[2] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pass_reg <= pass_next;
            comp_reg <= comp_next;
            ok_reg <= ok_next;
            out_valid_reg <= out_valid_next;
            hfwd_reg <= hfwd_next;
            hside_reg <= hside_next;
            up_reg <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
        acc_reg <= acc_next;
        prod_reg <= prod_next;
        n_reg <= n_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        quo_reg <= quo_next;
        fwd_w_reg <= fwd_w_next;
        side_w_reg <= side_w_next;
        up_w_reg <= up_w_next;
        out_reg <= out_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tangent.valid && tangent.ready |=> !tangent.ready)
        else $error("input ready right after accepting a tangent");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == 5'd0 |-> quo_new <= 15'd16384)
        else $error("unit component above one");

    a_up_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !(up_reg[0] == 16'sd0 && up_reg[1] == 16'sd0 && up_reg[2] == 16'sd0))
        else $error("stored up vector is zero");

    a_root_zero_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT && cnt_reg == 5'd31 && root_new == 32'd0 |=> !ok_reg)
        else $error("zero length not flagged");

endmodule
